// File: hdl/smtu_pkg.sv
// ----------------------------------------------------------------------------
// smtu_pkg
// Shared types and constants of the multi-turn servo position unwrapper.
// ----------------------------------------------------------------------------
package smtu_pkg;

  // Channel and sample geometry
  localparam int unsigned CHANNELS      = 3;
  localparam int unsigned CH_W          = 2;
  localparam int unsigned SERVO_BITS    = 10;
  localparam int unsigned DEADBAND      = 8;
  localparam int unsigned FULL_SCALE    = (1 << SERVO_BITS) - 1;
  localparam int unsigned LIMIT_CHANNEL = 1;

  // Deadband edges on the raw reading
  localparam logic [SERVO_BITS-1:0] DB_LO    = SERVO_BITS'(DEADBAND);
  localparam logic [SERVO_BITS-1:0] DB_HI    = SERVO_BITS'(FULL_SCALE - DEADBAND);
  localparam logic [SERVO_BITS-1:0] BAND_LO  = SERVO_BITS'(2 * DEADBAND);
  localparam logic [SERVO_BITS-1:0] BAND_HI  = SERVO_BITS'(FULL_SCALE - 2 * DEADBAND);
  localparam logic [SERVO_BITS-1:0] POS_FULL = SERVO_BITS'(FULL_SCALE);

  // Datapath widths
  localparam int unsigned WRAP_W     = 8;
  localparam int unsigned UNW_W      = SERVO_BITS + WRAP_W;
  localparam int unsigned SCALE_W    = 32;
  localparam int unsigned ANGLE_W    = 24;
  localparam int unsigned LIMIT_W    = 23;
  localparam int unsigned PROD_W     = UNW_W + SCALE_W;
  localparam int unsigned FRAC_SHIFT = 14;
  localparam int unsigned RND_W      = PROD_W - FRAC_SHIFT;
  localparam int unsigned SUM_W      = RND_W + 1;

  // Reset values
  localparam logic signed [WRAP_W-1:0]  WRAP_RESET  = '1;
  localparam logic signed [SCALE_W-1:0] SCALE_RESET = SCALE_W'(6594646);
  localparam logic [LIMIT_W-1:0]        LIMIT_RESET = LIMIT_W'(163840);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_CH0  = 3'd0,
    REG_OFFSET_CH1  = 3'd1,
    REG_OFFSET_CH2  = 3'd2,
    REG_SCALE_CH0   = 3'd3,
    REG_SCALE_CH1   = 3'd4,
    REG_SCALE_CH2   = 3'd5,
    REG_WRIST_LIMIT = 3'd6
  } cfg_reg_e;

  // Stream layout
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned IN_TUSER_W  = CH_W;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned ANGLE_LSB   = 0;
  localparam int unsigned UNW_LSB     = ANGLE_LSB + ANGLE_W;
  localparam int unsigned WRAP_LSB    = UNW_LSB + UNW_W;
  localparam int unsigned ZONE_LSB    = WRAP_LSB + WRAP_W;
  localparam int unsigned HIT_LSB     = ZONE_LSB + 2;
  localparam int unsigned OUT_USED_W  = HIT_LSB + 2;

  typedef enum logic [1:0] {
    ZONE_NONE = 2'd0,
    ZONE_LOW  = 2'd1,
    ZONE_HIGH = 2'd2
  } zone_e;

  typedef enum logic [1:0] {
    HIT_NONE  = 2'd0,
    HIT_BELOW = 2'd1,
    HIT_ABOVE = 2'd2
  } hit_e;

  // One word of the per-channel state memory
  typedef struct packed {
    zone_e                     zone;
    logic signed [WRAP_W-1:0]  wraps;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{zone: ZONE_NONE, wraps: WRAP_RESET};

endpackage

// File: hdl/servo_multiturn_unwrap.sv
// ----------------------------------------------------------------------------
// servo_multiturn_unwrap
// Multi-turn unwrapping of single-turn servo pot readings with wrap hysteresis.
// ----------------------------------------------------------------------------
// Each input transfer carries one 10-bit pot reading and its channel (tuser).
// Per channel a wrap count and a wrap zone live in a three-entry state memory
// (registered read port, per-entry valid bits, so no clearing pass after
// reset). A reading below the low deadband after being near the top counts a
// turn up, one above the high deadband after being near the bottom counts a
// turn down; middle-band readings while a zone is still held are pinned to 0
// or full scale. The result is offset + (pos + 1024*wraps) * scale in Q8.16,
// saturated to 24 bits. On channel 1 an angle beyond +-wrist_limit moves the
// stored wrap count back one turn for later readings. Throughput is one
// transfer per cycle unless the output stalls or a channel 1 reading waits;
// one waits while an earlier channel 1 reading is in stage 1 or 2 or stalled
// in stage 3, as its limit correction is written back from the last stage.
// Readings for channel 3 give an all-zero result and leave the state alone.
// Configuration writes are always ready and must only be issued while idle.
// ----------------------------------------------------------------------------
module servo_multiturn_unwrap
  import smtu_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [9:0] raw_position, [15:10] zero
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // [1:0] channel
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [23:0] angle, [41:24] unwrapped_count,
                                                  // [49:42] wrap_count_out, [51:50] zone_out,
                                                  // [53:52] limit_hit, [55:54] zero
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [ANGLE_W-1:0] offset_q [CHANNELS];
  logic signed [SCALE_W-1:0] scale_q  [CHANNELS];
  logic        [LIMIT_W-1:0] limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        offset_q[i] <= '0;
        scale_q[i]  <= SCALE_RESET;
      end
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_OFFSET_CH0:  offset_q[0] <= cfg_data_i[ANGLE_W-1:0];
        REG_OFFSET_CH1:  offset_q[1] <= cfg_data_i[ANGLE_W-1:0];
        REG_OFFSET_CH2:  offset_q[2] <= cfg_data_i[ANGLE_W-1:0];
        REG_SCALE_CH0:   scale_q[0]  <= cfg_data_i[SCALE_W-1:0];
        REG_SCALE_CH1:   scale_q[1]  <= cfg_data_i[SCALE_W-1:0];
        REG_SCALE_CH2:   scale_q[2]  <= cfg_data_i[SCALE_W-1:0];
        REG_WRIST_LIMIT: limit_q     <= cfg_data_i[LIMIT_W-1:0];
        default: ;  // index beyond the register list: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Saturating wrap count steps
  // --------------------------------------------------------------------------
  function automatic logic signed [WRAP_W-1:0] wrap_up(logic signed [WRAP_W-1:0] w);
    logic signed [WRAP_W-1:0] max_v;
    max_v = {1'b0, {(WRAP_W-1){1'b1}}};
    return (w == max_v) ? w : w + WRAP_W'(1);
  endfunction

  function automatic logic signed [WRAP_W-1:0] wrap_down(logic signed [WRAP_W-1:0] w);
    logic signed [WRAP_W-1:0] min_v;
    min_v = {1'b1, {(WRAP_W-1){1'b0}}};
    return (w == min_v) ? w : w - WRAP_W'(1);
  endfunction

  // --------------------------------------------------------------------------
  // Pipeline handshake
  // Stage 1: memory data, zone update. Stage 2: multiply. Stage 3: round,
  // offset, saturate, limit check, write back. Then the output register.
  // --------------------------------------------------------------------------
  logic                  s1_v_q, s2_v_q, s3_v_q, m_v_q;
  logic [CH_W-1:0]       s1_ch_q, s2_ch_q, s3_ch_q;
  logic                  s1_ok_q, s2_ok_q, s3_ok_q;
  logic                  out_en, s3_free, s2_free, s1_free;
  logic                  s3_adv, s2_adv, s1_adv;
  logic                  in_accept, in_lock, in_ok;
  logic [CH_W-1:0]       in_ch;

  assign in_ch     = s_axis_tuser;
  assign in_ok     = (in_ch < CH_W'(CHANNELS));

  assign out_en    = !m_v_q || m_axis_tready;
  assign s3_free   = !s3_v_q || out_en;
  assign s3_adv    = s3_v_q && out_en;
  assign s2_free   = !s2_v_q || s3_free;
  assign s2_adv    = s2_v_q && s3_free;
  assign s1_free   = !s1_v_q || s2_free;
  assign s1_adv    = s1_v_q && s2_free;

  // Hold a channel 1 reading back until the previous one leaves stage 3,
  // so its wrap count already carries the limit correction.
  assign in_lock = (in_ch == CH_W'(LIMIT_CHANNEL)) &&
                   ((s1_v_q && s1_ch_q == CH_W'(LIMIT_CHANNEL)) ||
                    (s2_v_q && s2_ch_q == CH_W'(LIMIT_CHANNEL)) ||
                    (s3_v_q && s3_ch_q == CH_W'(LIMIT_CHANNEL) && !out_en));

  assign s_axis_tready = s1_free && !in_lock;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      m_v_q  <= 1'b0;
    end else begin
      if (in_accept)   s1_v_q <= 1'b1;
      else if (s1_adv) s1_v_q <= 1'b0;
      if (s1_adv)      s2_v_q <= 1'b1;
      else if (s2_adv) s2_v_q <= 1'b0;
      if (s2_adv)      s3_v_q <= 1'b1;
      else if (s3_adv) s3_v_q <= 1'b0;
      if (s3_adv)      m_v_q  <= 1'b1;
      else if (out_en) m_v_q  <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // State memory: one entry per channel, read at transfer, written from stage 3
  // --------------------------------------------------------------------------
  entry_t          mem_q [CHANNELS];
  logic            mem_vld_q [CHANNELS];
  entry_t          rd_q;
  logic            rd_vld_q;
  logic            wr_en;
  entry_t          wr_data;
  entry_t          w_q;        // last write, forwarded to a read that missed it
  logic [CH_W-1:0] w_ch_q;
  logic            w_v_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[s3_ch_q] <= wr_data;
    end
    if (in_accept && in_ok) begin
      rd_q <= mem_q[in_ch];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        mem_vld_q[i] <= 1'b0;
      end
      rd_vld_q <= 1'b0;
      w_v_q    <= 1'b0;
    end else begin
      if (wr_en) begin
        mem_vld_q[s3_ch_q] <= 1'b1;
        w_v_q              <= 1'b1;
      end
      if (in_accept) begin
        rd_vld_q <= in_ok && mem_vld_q[in_ch];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      w_q    <= wr_data;
      w_ch_q <= s3_ch_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: pick the freshest state, update zone and wrap count
  // --------------------------------------------------------------------------
  logic [SERVO_BITS-1:0]     s1_pos_q;
  entry_t                    s2_ent_q, s3_ent_q;
  entry_t                    cur;
  zone_e                     zone_d;
  logic signed [WRAP_W-1:0]  wraps_d;
  logic [SERVO_BITS-1:0]     pos_d;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_ch_q  <= in_ch;
      s1_ok_q  <= in_ok;
      s1_pos_q <= s_axis_tdata[SERVO_BITS-1:0];
    end
  end

  always_comb begin
    // Newer in-flight entries of the same channel win over the memory read
    if (s2_v_q && s2_ok_q && s2_ch_q == s1_ch_q) begin
      cur = s2_ent_q;
    end else if (s3_v_q && s3_ok_q && s3_ch_q == s1_ch_q) begin
      cur = s3_ent_q;
    end else if (w_v_q && w_ch_q == s1_ch_q) begin
      cur = w_q;
    end else if (rd_vld_q) begin
      cur = rd_q;
    end else begin
      cur = ENTRY_RESET;
    end

    zone_d  = cur.zone;
    wraps_d = cur.wraps;
    pos_d   = s1_pos_q;
    if (s1_pos_q < DB_LO) begin
      if (cur.zone == ZONE_HIGH) wraps_d = wrap_up(cur.wraps);
      zone_d = ZONE_LOW;
    end else if (s1_pos_q > DB_HI) begin
      if (cur.zone == ZONE_LOW) wraps_d = wrap_down(cur.wraps);
      zone_d = ZONE_HIGH;
    end else if (s1_pos_q < BAND_LO || s1_pos_q > BAND_HI) begin
      zone_d = ZONE_NONE;
    end else if (cur.zone != ZONE_NONE) begin
      // still inside a wrap: pin the scratchy middle reading to the rail
      pos_d = (cur.zone == ZONE_HIGH) ? POS_FULL : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: unwrapped count times channel scale
  // --------------------------------------------------------------------------
  logic signed [UNW_W-1:0]   s2_unw_q, s3_unw_q;
  logic signed [SCALE_W-1:0] scale_sel;
  logic signed [PROD_W-1:0]  prod_d, s3_prod_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_ch_q        <= s1_ch_q;
      s2_ok_q        <= s1_ok_q;
      s2_ent_q.zone  <= zone_d;
      s2_ent_q.wraps <= wraps_d;
      // pos < 2^SERVO_BITS, so pos + 2^SERVO_BITS * wraps is a concatenation
      s2_unw_q       <= {wraps_d, pos_d};
    end
  end

  assign scale_sel = s2_ok_q ? scale_q[s2_ch_q] : '0;
  assign prod_d    = s2_unw_q * scale_sel;

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s3_ch_q   <= s2_ch_q;
      s3_ok_q   <= s2_ok_q;
      s3_ent_q  <= s2_ent_q;
      s3_unw_q  <= s2_unw_q;
      s3_prod_q <= prod_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: round to Q.16, add offset, saturate, channel 1 limit check
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0]  prod_rnd;
  logic signed [RND_W-1:0]   rnd;
  logic signed [ANGLE_W-1:0] offset_sel;
  logic signed [SUM_W-1:0]   sum, lim_pos, lim_neg, ang_max, ang_min;
  logic signed [ANGLE_W-1:0] angle_d;
  hit_e                      hit_d;
  logic signed [WRAP_W-1:0]  wraps_fix;

  assign prod_rnd   = s3_prod_q + PROD_W'(1 << (FRAC_SHIFT - 1));
  assign rnd        = prod_rnd[PROD_W-1:FRAC_SHIFT];
  assign offset_sel = s3_ok_q ? offset_q[s3_ch_q] : '0;
  assign sum        = {rnd[RND_W-1], rnd} +
                      {{(SUM_W-ANGLE_W){offset_sel[ANGLE_W-1]}}, offset_sel};
  assign ang_max    = {{(SUM_W-ANGLE_W+1){1'b0}}, {(ANGLE_W-1){1'b1}}};
  assign ang_min    = {{(SUM_W-ANGLE_W+1){1'b1}}, {(ANGLE_W-1){1'b0}}};
  assign lim_pos    = {{(SUM_W-LIMIT_W){1'b0}}, limit_q};
  assign lim_neg    = -lim_pos;

  always_comb begin
    if (sum > ang_max) begin
      angle_d = ang_max[ANGLE_W-1:0];
    end else if (sum < ang_min) begin
      angle_d = ang_min[ANGLE_W-1:0];
    end else begin
      angle_d = sum[ANGLE_W-1:0];
    end

    hit_d     = HIT_NONE;
    wraps_fix = s3_ent_q.wraps;
    if (s3_ok_q && s3_ch_q == CH_W'(LIMIT_CHANNEL)) begin
      if (sum < lim_neg) begin
        hit_d     = HIT_BELOW;
        wraps_fix = wrap_up(s3_ent_q.wraps);
      end else if (sum > lim_pos) begin
        hit_d     = HIT_ABOVE;
        wraps_fix = wrap_down(s3_ent_q.wraps);
      end
    end
  end

  assign wr_en         = s3_adv && s3_ok_q;
  assign wr_data.zone  = s3_ent_q.zone;
  assign wr_data.wraps = wraps_fix;

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [OUT_TDATA_W-1:0] m_data_q;

  always_ff @(posedge clk_i) begin
    if (s3_adv) begin
      if (s3_ok_q) begin
        m_data_q <= {(OUT_TDATA_W-OUT_USED_W)'(0), hit_d, s3_ent_q.zone,
                     s3_ent_q.wraps, s3_unw_q, angle_d};
      end else begin
        m_data_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = m_v_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// File: hdl/smtu_checker.sv
// ----------------------------------------------------------------------------
// smtu_checker
// Port-level checks on the result stream of the multi-turn unwrapper.
// ----------------------------------------------------------------------------
module smtu_checker
  import smtu_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [SERVO_BITS-1:0] pos_bits;
  logic [WRAP_W-1:0]     unw_turns;
  logic [WRAP_W-1:0]     wrap_field;
  logic [1:0]            zone_field;

  assign pos_bits   = m_axis_tdata[UNW_LSB +: SERVO_BITS];
  assign unw_turns  = m_axis_tdata[UNW_LSB + SERVO_BITS +: WRAP_W];
  assign wrap_field = m_axis_tdata[WRAP_LSB +: WRAP_W];
  assign zone_field = m_axis_tdata[ZONE_LSB +: 2];

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Unwrapped count carries the reported wrap count as its whole turns
  a_turns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> unw_turns == wrap_field)
    else $error("unwrapped count disagrees with wrap count");

  // Low zone leaves a position inside the low deadband or pinned to zero
  a_zone_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && zone_field == ZONE_LOW |-> pos_bits < DB_LO)
    else $error("low zone with position outside low deadband");

  // High zone leaves a position inside the high deadband or pinned to full scale
  a_zone_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && zone_field == ZONE_HIGH |-> pos_bits > DB_HI)
    else $error("high zone with position outside high deadband");

endmodule

bind servo_multiturn_unwrap smtu_checker u_smtu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
